[rtl/core/gait_phase_scheduler_core_macros.svh]
// ----------------------------------------------------------------------------
// Gait phase scheduler assertion macros
// Shorthand for clocked assertions that the scheduler modules share. Every
// macro samples on clk_i and is switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GAIT_PHASE_SCHEDULER_CORE_MACROS_SVH
`define GAIT_PHASE_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define GPS_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define GPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/gps_pkg.sv]
// ----------------------------------------------------------------------------
// Gait phase scheduler package
// Widths, reset values, register indexes, command codes, states and the
// payload and control types shared by the scheduler modules.
// ----------------------------------------------------------------------------
package gps_pkg;

  // Sizes.
  localparam int LegCountDefault = 6;
  localparam int OffsetLegs      = 6;
  localparam int OffsetW         = 8;
  localparam int PhaseW          = 16;
  localparam int AccW            = 32;
  localparam int MulW            = 16;
  localparam int ProdW           = 2 * MulW;
  localparam int GainFracW       = 12;
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 48;
  localparam int MaskW           = 6;
  localparam int LegIdxW         = 3;
  localparam int AdhCntW         = 3;
  localparam int VelW            = 16;
  localparam int YawThrW         = 15;

  // Register reset values.
  localparam logic [CfgDataW-1:0] OffsetsReset    = '0;
  localparam logic [PhaseW-1:0]   DutyReset       = 16'd54613;
  localparam logic [MulW-1:0]     GainReset       = 16'd24576;
  localparam logic [MulW-1:0]     RateReset       = 16'd2863;
  localparam logic                WallReset       = 1'b0;
  localparam logic [AdhCntW-1:0]  MinAdhReset     = 3'd3;
  localparam logic [AccW-1:0]     StillSpeedReset = 32'd10000;
  localparam logic [YawThrW-1:0]  StillYawReset   = 15'd100;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEG_OFFSETS = 3'd0,
    CFG_DUTY        = 3'd1,
    CFG_GAIN        = 3'd2,
    CFG_RATE        = 3'd3,
    CFG_WALL_MODE   = 3'd4,
    CFG_MIN_ADH     = 3'd5,
    CFG_STILL_SPEED = 3'd6,
    CFG_STILL_YAW   = 3'd7
  } gps_cfg_e;

  // Leg command codes.
  typedef enum logic [1:0] {
    CMD_STANCE = 2'd0,
    CMD_SWING  = 2'd1,
    CMD_FORCED = 2'd2
  } gps_cmd_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_START,
    ST_SQ_WAIT,
    ST_CHECK,
    ST_ADV_WAIT,
    ST_LEG,
    ST_LEG_WAIT,
    ST_LEG_PUT
  } gps_state_e;

  // Input beat.
  typedef struct packed {
    logic        [15:0]      dt_us;
    logic signed [VelW-1:0]  vel_x;
    logic signed [VelW-1:0]  vel_y;
    logic signed [VelW-1:0]  vel_z;
    logic signed [VelW-1:0]  yaw_speed;
    logic        [MaskW-1:0] adhered_mask;
  } gps_in_t;

  // Output beat.
  typedef struct packed {
    logic [LegIdxW-1:0] leg_index;
    logic [1:0]         leg_command;
    logic [PhaseW-1:0]  swing_frac;
    logic               last_leg;
  } gps_out_t;

  // Serial multiplier request and response.
  typedef struct packed {
    logic            start;
    logic [MulW-1:0] a;
    logic [MulW-1:0] b;
  } gps_mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] product;
  } gps_mul_rsp_t;

  // Per-leg decision.
  typedef struct packed {
    logic              swing;
    logic              refuse;
    logic [PhaseW-1:0] diff;
  } gps_leg_eval_t;

endpackage

[rtl/core/gps_serial_mul.sv]
// ----------------------------------------------------------------------------
// Gait phase scheduler bit-serial multiplier
// Unsigned shift-add multiplier that retires one multiplier bit per cycle.
// A start loads the operands; done pulses once the full product is ready.
// ----------------------------------------------------------------------------
module gps_serial_mul
  import gps_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gps_mul_req_t req_i,
  output gps_mul_rsp_t rsp_o
);

  localparam int CntW = $clog2(MulW);
  localparam logic [CntW-1:0] CntLast = CntW'(MulW - 1);

  logic            active_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [MulW-1:0] mcand_q;
  logic [MulW-1:0] hi_q;
  logic [MulW-1:0] lo_q;
  logic [MulW:0]   sum;

  // Add the multiplicand when the current multiplier bit is set.
  assign sum = {1'b0, hi_q} + {1'b0, (lo_q[0] ? mcand_q : {MulW{1'b0}})};

  // Control: step through each multiplier bit in turn, then flag completion.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // Datapath: the partial product shifts right into the multiplier register.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q <= req_i.a;
      hi_q    <= '0;
      lo_q    <= req_i.b;
    end else if (active_q) begin
      hi_q <= sum[MulW:1];
      lo_q <= {sum[0], lo_q[MulW-1:1]};
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = {hi_q, lo_q};

endmodule

[rtl/core/gps_leg_eval.sv]
// ----------------------------------------------------------------------------
// Gait phase scheduler leg evaluator
// Forms one leg's phase from the cycle phase and its offset, decides whether
// the leg is in swing, and checks in wall mode that enough other feet adhere.
// ----------------------------------------------------------------------------
module gps_leg_eval
  import gps_pkg::*;
#(
  parameter int LEG_COUNT = LegCountDefault
) (
  input  logic [LegIdxW-1:0]  leg_i,
  input  logic [PhaseW-1:0]   cycle_phase_i,
  input  logic [CfgDataW-1:0] offsets_i,
  input  logic [PhaseW-1:0]   duty_i,
  input  logic                wall_mode_i,
  input  logic [AdhCntW-1:0]  min_adhered_i,
  input  logic [MaskW-1:0]    mask_i,
  output gps_leg_eval_t       eval_o
);

  localparam int IdxSlots = 2 ** LegIdxW;

  logic [OffsetW-1:0] offset_tab [IdxSlots];
  logic [OffsetW-1:0] offset;
  logic [PhaseW-1:0]  leg_pos;
  logic [AdhCntW-1:0] others;

  // Offset bytes by leg; legs past the sixth have no offset.
  always_comb begin
    for (int k = 0; k < IdxSlots; k++) begin
      if (k < OffsetLegs) begin
        offset_tab[k] = offsets_i[k*OffsetW +: OffsetW];
      end else begin
        offset_tab[k] = '0;
      end
    end
  end

  assign offset  = offset_tab[leg_i];
  assign leg_pos = cycle_phase_i + {offset, {(PhaseW - OffsetW){1'b0}}};

  // Count the other adhered feet among the legs that exist.
  always_comb begin
    others = '0;
    for (int j = 0; j < MaskW; j++) begin
      if (j < LEG_COUNT && LegIdxW'(j) != leg_i && mask_i[j]) begin
        others = others + 1'b1;
      end
    end
  end

  assign eval_o.swing  = (leg_pos >= duty_i);
  assign eval_o.refuse = wall_mode_i && (others < min_adhered_i);
  assign eval_o.diff   = leg_pos - duty_i;

endmodule

[rtl/core/gait_phase_scheduler_core.sv]
// ----------------------------------------------------------------------------
// Gait phase scheduler core
// A moving tick squares the three velocity components, advances the phase and
// then shows one beat per leg, with a gain product for each leg let swing; a
// still tick ends after the still check with no beats. All products go one bit
// a cycle through the single shared 16-bit serial multiplier.
// Reset: asynchronous, active low; clears the phase and loads register defaults.
// ----------------------------------------------------------------------------
`include "gait_phase_scheduler_core_macros.svh"

module gait_phase_scheduler_core
  import gps_pkg::*;
#(
  parameter int LEG_COUNT = LegCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gps_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gps_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int LegW = $clog2(LEG_COUNT);
  localparam logic [LegW-1:0] LastLeg = LegW'(LEG_COUNT - 1);
  localparam logic [1:0]      SqLast  = 2'd2;
  localparam int SatLo = GainFracW + PhaseW;

  // Configuration registers.
  logic [CfgDataW-1:0] offsets_q;
  logic [PhaseW-1:0]   duty_q;
  logic [MulW-1:0]     gain_q;
  logic [MulW-1:0]     rate_q;
  logic                wall_q;
  logic [AdhCntW-1:0]  min_adh_q;
  logic [AccW-1:0]     still_speed_q;
  logic [YawThrW-1:0]  still_yaw_q;

  // Sequencer and datapath.
  gps_state_e     state_q, state_d;
  logic [1:0]     sq_idx_q, sq_idx_d;
  logic [LegW-1:0] leg_q, leg_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [AccW-1:0] speed_q, speed_d;
  gps_in_t        in_q;
  gps_out_t       res_q, res_d;
  gps_out_t       out_q;
  logic           out_valid_q;
  logic           out_load;
  logic           in_take;
  logic [MulW-1:0] vel_abs;
  logic [MulW-1:0] yaw_abs;
  logic           still;
  gps_mul_req_t   mul_req;
  gps_mul_rsp_t   mul_rsp;
  gps_leg_eval_t  eval;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offsets_q     <= OffsetsReset;
      duty_q        <= DutyReset;
      gain_q        <= GainReset;
      rate_q        <= RateReset;
      wall_q        <= WallReset;
      min_adh_q     <= MinAdhReset;
      still_speed_q <= StillSpeedReset;
      still_yaw_q   <= StillYawReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LEG_OFFSETS: offsets_q     <= cfg_wdata_i;
        CFG_DUTY:        duty_q        <= cfg_wdata_i[PhaseW-1:0];
        CFG_GAIN:        gain_q        <= cfg_wdata_i[MulW-1:0];
        CFG_RATE:        rate_q        <= cfg_wdata_i[MulW-1:0];
        CFG_WALL_MODE:   wall_q        <= cfg_wdata_i[0];
        CFG_MIN_ADH:     min_adh_q     <= cfg_wdata_i[AdhCntW-1:0];
        CFG_STILL_SPEED: still_speed_q <= cfg_wdata_i[AccW-1:0];
        CFG_STILL_YAW:   still_yaw_q   <= cfg_wdata_i[YawThrW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Magnitudes of the velocity component being squared and of the yaw rate.
  always_comb begin
    logic [VelW-1:0] v;
    case (sq_idx_q)
      2'd0:    v = in_q.vel_x;
      2'd1:    v = in_q.vel_y;
      default: v = in_q.vel_z;
    endcase
    vel_abs = v[VelW-1] ? (~v + 1'b1) : v;
    yaw_abs = in_q.yaw_speed[VelW-1] ? (~in_q.yaw_speed + 1'b1) : in_q.yaw_speed;
  end

  assign still = (speed_q < still_speed_q) && (yaw_abs < {1'b0, still_yaw_q});

  // Shared serial multiplier.
  gps_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Phase and swing decision for the current leg.
  gps_leg_eval #(
    .LEG_COUNT (LEG_COUNT)
  ) u_leg_eval (
    .leg_i         (LegIdxW'(leg_q)),
    .cycle_phase_i (acc_q[AccW-1:AccW-PhaseW]),
    .offsets_i     (offsets_q),
    .duty_i        (duty_q),
    .wall_mode_i   (wall_q),
    .min_adhered_i (min_adh_q),
    .mask_i        (in_q.adhered_mask),
    .eval_o        (eval)
  );

  // Sequencer: squares, still check, then unless still a phase advance and one command per leg.
  always_comb begin
    state_d   = state_q;
    sq_idx_d  = sq_idx_q;
    leg_d     = leg_q;
    acc_d     = acc_q;
    speed_d   = speed_q;
    res_d     = res_q;
    out_load  = 1'b0;
    in_take   = 1'b0;
    mul_req   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_take  = 1'b1;
          sq_idx_d = '0;
          speed_d  = '0;
          state_d  = ST_SQ_START;
        end
      end
      ST_SQ_START: begin
        mul_req.start = 1'b1;
        mul_req.a     = vel_abs;
        mul_req.b     = vel_abs;
        state_d       = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (mul_rsp.done) begin
          speed_d = speed_q + mul_rsp.product;
          if (sq_idx_q == SqLast) begin
            state_d = ST_CHECK;
          end else begin
            sq_idx_d = sq_idx_q + 1'b1;
            state_d  = ST_SQ_START;
          end
        end
      end
      ST_CHECK: begin
        if (still) begin
          state_d = ST_IDLE;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a     = in_q.dt_us;
          mul_req.b     = rate_q;
          state_d       = ST_ADV_WAIT;
        end
      end
      ST_ADV_WAIT: begin
        if (mul_rsp.done) begin
          acc_d   = acc_q + mul_rsp.product;
          leg_d   = '0;
          state_d = ST_LEG;
        end
      end
      ST_LEG: begin
        res_d.leg_index  = LegIdxW'(leg_q);
        res_d.last_leg   = (leg_q == LastLeg);
        res_d.swing_frac = '0;
        if (eval.swing && !eval.refuse) begin
          mul_req.start = 1'b1;
          mul_req.a     = eval.diff;
          mul_req.b     = gain_q;
          state_d       = ST_LEG_WAIT;
        end else begin
          res_d.leg_command = eval.swing ? CMD_FORCED : CMD_STANCE;
          state_d           = ST_LEG_PUT;
        end
      end
      ST_LEG_WAIT: begin
        if (mul_rsp.done) begin
          res_d.leg_command = CMD_SWING;
          if (|mul_rsp.product[ProdW-1:SatLo]) begin
            res_d.swing_frac = '1;
          end else begin
            res_d.swing_frac = mul_rsp.product[SatLo-1:GainFracW];
          end
          state_d = ST_LEG_PUT;
        end
      end
      ST_LEG_PUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (res_q.last_leg) begin
            state_d = ST_IDLE;
          end else begin
            leg_d   = leg_q + 1'b1;
            state_d = ST_LEG;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and phase accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sq_idx_q    <= '0;
      leg_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sq_idx_q <= sq_idx_d;
      leg_q    <= leg_d;
      acc_q    <= acc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    speed_q <= speed_d;
    res_q   <= res_d;
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks.
  `GPS_ASSERT_IMPLY(a_prog_zero_unless_swing,
    out_valid_o && out_data_o.leg_command != CMD_SWING,
    out_data_o.swing_frac == '0, "swing fraction set on a non-swing beat")
  `GPS_ASSERT_IMPLY(a_cmd_legal, out_valid_o,
    out_data_o.leg_command == CMD_STANCE || out_data_o.leg_command == CMD_SWING ||
    out_data_o.leg_command == CMD_FORCED, "illegal leg command on output")
  `GPS_ASSERT_IMPLY(a_mul_done_expected, mul_rsp.done,
    state_q == ST_SQ_WAIT || state_q == ST_ADV_WAIT || state_q == ST_LEG_WAIT,
    "multiplier finished outside a wait state")
  `GPS_ASSERT_NEXT(a_last_leg_ends_tick, out_load && res_q.last_leg,
    state_q == ST_IDLE, "sequencer did not return to idle after the last leg")
  `GPS_ASSERT_NEXT(a_phase_holds_idle, state_q == ST_IDLE, $stable(acc_q),
    "phase changed while idle")

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gait phase scheduler core testbench
// Sends tick beats to the scheduler and checks every leg beat it returns
// against an in-bench model of the phase accumulator and the per-leg stance,
// swing and wall-refusal decisions. A short table of directed ticks comes
// first, then random phases under changing register settings and idling.
// ----------------------------------------------------------------------------
module tb;
  import gps_pkg::*;

  localparam int SettleCycles  = 200;
  localparam int HoldOffCycles = 3000;
  localparam int TicksPerPhase = 66;
  localparam int PhaseCount    = 6;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_STILL,
    ROW_ALL,
    ROW_PRED
  } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    gps_cfg_e            idx;
    logic [CfgDataW-1:0] val;
    gps_in_t             beat;
    gps_cmd_e            cmd;
    logic [PhaseW-1:0]   prog;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  gps_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  gps_out_t            out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  // Register copies and phase accumulator of the scheduler model.
  logic [CfgDataW-1:0] offsets_q     = OffsetsReset;
  logic [PhaseW-1:0]   duty_q        = DutyReset;
  logic [MulW-1:0]     gain_q        = GainReset;
  logic [MulW-1:0]     rate_q        = RateReset;
  logic                wall_q        = WallReset;
  logic [AdhCntW-1:0]  min_adh_q     = MinAdhReset;
  logic [AccW-1:0]     still_speed_q = StillSpeedReset;
  logic [YawThrW-1:0]  still_yaw_q   = StillYawReset;
  logic [AccW-1:0]     phase_acc     = '0;

  gps_out_t pending_legs[$];
  gps_out_t want;
  int       n_err       = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  bit       hold_req    = 1'b0;

  // Directed ticks; ALL rows give the command and progress of every leg.
  dir_row_t dir_tbl [0:33] = '{
    '{ROW_STILL, CFG_LEG_OFFSETS, '0, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 6'h00},
      CMD_STANCE, 16'd0},
    '{ROW_ALL, CFG_LEG_OFFSETS, '0, '{16'd0, 16'd100, 16'd0, 16'd0, 16'd0, 6'h00},
      CMD_STANCE, 16'd0},
    '{ROW_ALL, CFG_LEG_OFFSETS, '0, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd100, 6'h00},
      CMD_STANCE, 16'd0},
    '{ROW_STILL, CFG_LEG_OFFSETS, '0, '{16'd1000, 16'd99, 16'd0, 16'd0, 16'hFF9D, 6'h3F},
      CMD_STANCE, 16'd0},
    '{ROW_PRED, CFG_LEG_OFFSETS, '0,
      '{16'hFFFF, 16'd8000, 16'd8000, 16'd8000, 16'h8000, 6'h2A}, CMD_STANCE, 16'd0},
    '{ROW_PRED, CFG_LEG_OFFSETS, '0,
      '{16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 6'h3F}, CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_RATE, 48'hFFFF, '0, CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_GAIN, 48'h0, '0, CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_DUTY, 48'h0, '0, CMD_STANCE, 16'd0},
    '{ROW_ALL, CFG_LEG_OFFSETS, '0, '{16'd1, 16'h7FFF, 16'd0, 16'd0, 16'd0, 6'h00},
      CMD_SWING, 16'd0},
    '{ROW_CFG, CFG_GAIN, 48'hFFFF, '0, CMD_STANCE, 16'd0},
    '{ROW_PRED, CFG_LEG_OFFSETS, '0, '{16'hFFFF, 16'd0, 16'd0, 16'd100, 16'd0, 6'h15},
      CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_LEG_OFFSETS, 48'hFF80_4020_1001, '0, CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_DUTY, 48'hFFFF, '0, CMD_STANCE, 16'd0},
    '{ROW_PRED, CFG_LEG_OFFSETS, '0, '{16'd40000, 16'd0, 16'd0, 16'd0, 16'hFF00, 6'h00},
      CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_WALL_MODE, 48'h1, '0, CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_MIN_ADH, 48'h7, '0, CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_DUTY, 48'h0, '0, CMD_STANCE, 16'd0},
    '{ROW_ALL, CFG_LEG_OFFSETS, '0, '{16'd7, 16'd0, 16'd0, 16'd0, 16'd200, 6'h3F},
      CMD_FORCED, 16'd0},
    '{ROW_CFG, CFG_MIN_ADH, 48'h0, '0, CMD_STANCE, 16'd0},
    '{ROW_PRED, CFG_LEG_OFFSETS, '0, '{16'd123, 16'd0, 16'd0, 16'd0, 16'd500, 6'h00},
      CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_MIN_ADH, 48'h3, '0, CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_DUTY, 48'h8000, '0, CMD_STANCE, 16'd0},
    '{ROW_PRED, CFG_LEG_OFFSETS, '0, '{16'd2500, 16'd0, 16'd300, 16'd0, 16'd0, 6'h07},
      CMD_STANCE, 16'd0},
    '{ROW_PRED, CFG_LEG_OFFSETS, '0, '{16'd9000, 16'd0, 16'd300, 16'd0, 16'd0, 6'h38},
      CMD_STANCE, 16'd0},
    '{ROW_PRED, CFG_LEG_OFFSETS, '0, '{16'd31000, 16'd0, 16'd300, 16'd0, 16'd0, 6'h3F},
      CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_STILL_SPEED, 48'h0, '0, CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_STILL_YAW, 48'h0, '0, CMD_STANCE, 16'd0},
    '{ROW_PRED, CFG_LEG_OFFSETS, '0, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 6'h00},
      CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_STILL_SPEED, 48'hFFFF_FFFF, '0, CMD_STANCE, 16'd0},
    '{ROW_CFG, CFG_STILL_YAW, 48'h7FFF, '0, CMD_STANCE, 16'd0},
    '{ROW_STILL, CFG_LEG_OFFSETS, '0,
      '{16'd5000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFE, 6'h00}, CMD_STANCE, 16'd0},
    '{ROW_PRED, CFG_LEG_OFFSETS, '0, '{16'd5000, 16'd0, 16'd0, 16'd0, 16'h8001, 6'h00},
      CMD_STANCE, 16'd0},
    '{ROW_PRED, CFG_LEG_OFFSETS, '0, '{16'd5000, 16'd0, 16'd0, 16'd0, 16'h8000, 6'h00},
      CMD_STANCE, 16'd0}
  };

  gait_phase_scheduler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Clock generation.
  always #5 clk_i = ~clk_i;

  // Model of one tick: returns the number of leg beats and fills them in.
  function automatic int advance_gait(input gps_in_t b, output gps_out_t legs [LegCountDefault]);
    int                 vx, vy, vz, yaw_abs, others;
    logic [AccW-1:0]    speed_sq, span, prod;
    logic [PhaseW-1:0]  leg_pos;
    logic [OffsetW-1:0] off;
    vx      = b.vel_x;
    vy      = b.vel_y;
    vz      = b.vel_z;
    yaw_abs = b.yaw_speed;
    if (yaw_abs < 0) begin
      yaw_abs = -yaw_abs;
    end
    speed_sq = AccW'(vx * vx + vy * vy + vz * vz);
    // A still body leaves the phase alone and commands nothing.
    if (speed_sq < still_speed_q && yaw_abs < int'(still_yaw_q)) begin
      return 0;
    end
    phase_acc = phase_acc + AccW'(b.dt_us) * AccW'(rate_q);
    for (int i = 0; i < LegCountDefault; i++) begin
      off     = (i < OffsetLegs) ? offsets_q[OffsetW*i +: OffsetW] : '0;
      leg_pos = phase_acc[AccW-1 -: PhaseW] + {off, 8'h00};
      // The mask holds one bit per leg, so the shift stays within it.
      others  = $countones(b.adhered_mask & ~(MaskW'(1) << i));
      legs[i]             = '0;
      legs[i].leg_index   = LegIdxW'(i);
      legs[i].last_leg    = (i == LegCountDefault - 1);
      legs[i].leg_command = CMD_STANCE;
      if (leg_pos >= duty_q) begin
        if (wall_q && others < int'(min_adh_q)) begin
          legs[i].leg_command = CMD_FORCED;
        end else begin
          span = AccW'(leg_pos) - AccW'(duty_q);
          prod = (span * AccW'(gain_q)) >> GainFracW;
          legs[i].leg_command = CMD_SWING;
          legs[i].swing_frac  = (prod > 32'hFFFF) ? 16'hFFFF : prod[PhaseW-1:0];
        end
      end
    end
    return LegCountDefault;
  endfunction

  // Offer one tick beat and hold it until the block takes it.
  task automatic send_beat(input gps_in_t b);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
  endtask

  // Send a tick and queue the leg beats it should produce.
  task automatic offer_tick(input gps_in_t b, input row_kind_e kind, input gps_cmd_e cmd,
                            input logic [PhaseW-1:0] prog);
    gps_out_t legs [LegCountDefault];
    int       n;
    send_beat(b);
    n = advance_gait(b, legs);
    if (kind == ROW_STILL) begin
      n = 0;
    end
    for (int i = 0; i < n; i++) begin
      if (kind == ROW_ALL) begin
        legs[i].leg_command = cmd;
        legs[i].swing_frac  = prog;
      end
      pending_legs = {pending_legs, legs[i]};
    end
  endtask

  // Drop valid, wait for every leg beat, then give a still tick time to end.
  task automatic settle(input int extra);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_legs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (extra) @(posedge clk_i);
  endtask

  // Register write; the model copy follows at once since the block is idle.
  task automatic write_reg(input gps_cfg_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LEG_OFFSETS: offsets_q     = val;
      CFG_DUTY:        duty_q        = val[PhaseW-1:0];
      CFG_GAIN:        gain_q        = val[MulW-1:0];
      CFG_RATE:        rate_q        = val[MulW-1:0];
      CFG_WALL_MODE:   wall_q        = val[0];
      CFG_MIN_ADH:     min_adh_q     = val[AdhCntW-1:0];
      CFG_STILL_SPEED: still_speed_q = val[AccW-1:0];
      CFG_STILL_YAW:   still_yaw_q   = val[YawThrW-1:0];
      default: ;
    endcase
  endtask

  task automatic report(input string field, input int unsigned exp_v, input int unsigned got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    n_err++;
  endtask

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Compare each accepted leg beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_legs.size() == 0) begin
        $display("%0t: unexpected leg beat, expected none, got %h", $time, out_data_o);
        n_err++;
      end else begin
        want = pending_legs.pop_front();
        if (out_data_o.leg_index !== want.leg_index) begin
          report("leg_index", want.leg_index, out_data_o.leg_index);
        end
        if (out_data_o.leg_command !== want.leg_command) begin
          report("leg_command", want.leg_command, out_data_o.leg_command);
        end
        if (out_data_o.swing_frac !== want.swing_frac) begin
          report("swing_frac", want.swing_frac, out_data_o.swing_frac);
        end
        if (out_data_o.last_leg !== want.last_leg) begin
          report("last_leg", want.last_leg, out_data_o.last_leg);
        end
      end
    end
  end

  // Stimulus: directed table, then random phases under new settings.
  initial begin : stimulus
    gps_in_t             t;
    logic [CfgDataW-1:0] v;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_LEG_OFFSETS;
    cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[r]) begin
      if (dir_tbl[r].kind == ROW_CFG) begin
        settle(SettleCycles);
        write_reg(dir_tbl[r].idx, dir_tbl[r].val);
      end else begin
        offer_tick(dir_tbl[r].beat, dir_tbl[r].kind, dir_tbl[r].cmd, dir_tbl[r].prog);
      end
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      settle(SettleCycles);
      // Fresh register settings, extremes mixed in.
      case ($urandom_range(0, 2))
        0:       v = '0;
        1:       v = '1;
        default: v = CfgDataW'({$urandom, $urandom});
      endcase
      write_reg(CFG_LEG_OFFSETS, v);
      case ($urandom_range(0, 3))
        0:       v = '0;
        1:       v = CfgDataW'(16'hFFFF);
        default: v = CfgDataW'($urandom_range(0, 65535));
      endcase
      write_reg(CFG_DUTY, v);
      case ($urandom_range(0, 3))
        0:       v = '0;
        1:       v = CfgDataW'(16'hFFFF);
        default: v = CfgDataW'($urandom_range(0, 65535));
      endcase
      write_reg(CFG_GAIN, v);
      v = ($urandom_range(0, 3) == 0) ? CfgDataW'(16'hFFFF) : CfgDataW'($urandom_range(0, 65535));
      write_reg(CFG_RATE, v);
      write_reg(CFG_WALL_MODE, CfgDataW'($urandom_range(0, 1)));
      write_reg(CFG_MIN_ADH, CfgDataW'($urandom_range(0, 7)));
      case ($urandom_range(0, 2))
        0:       v = '0;
        1:       v = CfgDataW'(StillSpeedReset);
        default: v = CfgDataW'($urandom_range(0, 1 << 20));
      endcase
      write_reg(CFG_STILL_SPEED, v);
      case ($urandom_range(0, 2))
        0:       v = '0;
        1:       v = CfgDataW'(StillYawReset);
        default: v = CfgDataW'($urandom_range(0, 32767));
      endcase
      write_reg(CFG_STILL_YAW, v);

      // Sender and receiver idling by phase pair.
      tx_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 46 : 0;
      rx_idle_pct = (ph < 2) ? 46 : (ph < 4) ? 30 : 0;
      if (ph == 4) begin
        hold_req = 1'b1;
      end

      for (int k = 0; k < TicksPerPhase; k++) begin
        if (ph == 2 && k == TicksPerPhase / 2) begin
          settle(0);
        end
        t.dt_us = PhaseW'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          t.dt_us = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        end
        // A quarter of the ticks sit near the still thresholds.
        if ($urandom_range(0, 3) == 0) begin
          t.vel_x     = VelW'(int'($urandom_range(0, 240)) - 120);
          t.vel_y     = VelW'(int'($urandom_range(0, 240)) - 120);
          t.vel_z     = VelW'(int'($urandom_range(0, 240)) - 120);
          t.yaw_speed = VelW'(int'($urandom_range(0, 300)) - 150);
        end else begin
          t.vel_x     = VelW'($urandom);
          t.vel_y     = VelW'($urandom);
          t.vel_z     = VelW'($urandom);
          t.yaw_speed = VelW'($urandom);
        end
        t.adhered_mask = MaskW'($urandom);
        offer_tick(t, ROW_PRED, CMD_STANCE, '0);
      end
    end

    settle(SettleCycles);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #(15_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
